@@ sv/vmt_pkg.sv @@
package vmt_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NUM_W     = 32 + FRAC_BITS;   // quotient bits, one cell per bit
   localparam int PROD_W    = 64;
   localparam int SUM_W     = PROD_W + 2;

   localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_VEC  = 2'd1,
      ACT_PNT  = 2'd2,
      ACT_DIR  = 2'd3
   } action_type;

   // Side data that rides along the divider chain with each request
   typedef struct packed {
      logic                    valid;
      action_type              action;
      logic [2:0][31:0]        num;
      logic signed [31:0]      den;
      logic [31:0]             den_mag;
   } div_ctrl_type;

endpackage

@@ sv/vmt_div_cell.sv @@
module vmt_div_cell (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [31:0]                  den_mag,
   input  logic [31:0]                  rem_in,
   input  logic [vmt_pkg::NUM_W-1:0]    nq_in,
   output logic [31:0]                  rem_ff,
   output logic [vmt_pkg::NUM_W-1:0]    nq_ff
);

   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;

   // One restoring step: bring down the next numerator bit, subtract if it fits
   always_comb begin
      trial = {rem_in, nq_in[vmt_pkg::NUM_W-1]};
      diff  = trial - {1'b0, den_mag};
      fits  = trial >= {1'b0, den_mag};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= fits ? diff[31:0] : trial[31:0];
         nq_ff  <= {nq_in[vmt_pkg::NUM_W-2:0], fits};
      end
   end

endmodule

@@ sv/vertex_matrix_transform_top.sv @@
// 4x4 column-major Q16.16 matrix transform. The matrix resets to identity; a load
// request (tuser 0) writes one element and returns nothing. Tuser 1 multiplies
// the vector by the matrix, 2 treats w as one and divides x, y, z by the result
// w, 3 applies the upper 3x3 and divides by m33. Sums and quotients saturate;
// a zero divisor saturates x, y, z by numerator sign and raises the fault flag
// in rsp_tuser. One request is taken every cycle while the result side keeps
// up. The divider chain retires one quotient bit per cell. A load takes effect
// for the very next request. The whole pipeline holds while a result waits unread.
module vertex_matrix_transform_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [3:0] element_index, [35:4] in_x, [67:36] in_y, [99:68] in_z,
   // [131:100] in_w, [135:132] zero
   input  logic [135:0]  req_tdata,
   // [1:0] action
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
   output logic [127:0]  rsp_tdata,
   // [0] divide_fault
   output logic          rsp_tuser
);

   localparam int NW = vmt_pkg::NUM_W;
   localparam int FB = vmt_pkg::FRAC_BITS;

   logic advance;
   logic req_accept;
   vmt_pkg::action_type req_action;

   logic signed [31:0] matrix_ff [16];

   // stage 1: captured request
   logic                      s1_valid_ff;
   vmt_pkg::action_type       s1_action_ff;
   logic signed [31:0]        s1_v_ff [4];

   // stage 2: products
   logic                      s2_valid_ff;
   vmt_pkg::action_type       s2_action_ff;
   logic signed [31:0]        s2_m33_ff;
   logic signed [63:0]        s2_prod_ff [16];

   // stage 3: exact row sums
   logic                      s3_valid_ff;
   vmt_pkg::action_type       s3_action_ff;
   logic signed [31:0]        s3_m33_ff;
   logic signed [vmt_pkg::SUM_W-1:0] s3_sum_ff [4];

   // stage 4: scaled and saturated rows
   logic                      s4_valid_ff;
   vmt_pkg::action_type       s4_action_ff;
   logic signed [31:0]        s4_m33_ff;
   logic signed [31:0]        s4_row_ff [4];
   logic signed [vmt_pkg::SUM_W-1:0] row_shift [4];

   // divider chain
   vmt_pkg::div_ctrl_type     ctrl_ff [NW+1];
   vmt_pkg::div_ctrl_type     ctrl_in;
   logic [NW-1:0]             nq_seed_ff [3];
   logic [31:0]               rem_w [3][NW+1];
   logic [NW-1:0]             nq_w  [3][NW+1];

   // output register
   logic                      rsp_valid_ff;
   logic [127:0]              rsp_data_ff;
   logic                      rsp_fault_ff;
   logic [127:0]              rsp_data_in;
   logic                      rsp_fault_in;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign req_accept = req_tvalid && advance;
   assign req_action = vmt_pkg::action_type'(req_tuser);

   // matrix store, written by load requests
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            matrix_ff[i] <= (i % 5 == 0) ? vmt_pkg::ONE : 32'sd0;
         end
      end else if (req_accept && req_action == vmt_pkg::ACT_LOAD) begin
         matrix_ff[req_tdata[3:0]] <= req_tdata[35:4];
      end
   end

   // valid bits: advance together, loads leave a bubble
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_accept && req_action != vmt_pkg::ACT_LOAD;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         row_shift[r] = s3_sum_ff[r] >>> FB;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_action_ff <= req_action;
         s1_v_ff[0]   <= req_tdata[35:4];
         s1_v_ff[1]   <= req_tdata[67:36];
         s1_v_ff[2]   <= req_tdata[99:68];
         unique case (req_action)
            vmt_pkg::ACT_VEC: s1_v_ff[3] <= req_tdata[131:100];
            vmt_pkg::ACT_PNT: s1_v_ff[3] <= vmt_pkg::ONE;
            default:          s1_v_ff[3] <= 32'sd0;
         endcase

         s2_action_ff <= s1_action_ff;
         s2_m33_ff    <= matrix_ff[15];
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
               s2_prod_ff[c*4+r] <= matrix_ff[c*4+r] * s1_v_ff[c];
            end
         end

         s3_action_ff <= s2_action_ff;
         s3_m33_ff    <= s2_m33_ff;
         for (int r = 0; r < 4; r++) begin
            s3_sum_ff[r] <= vmt_pkg::SUM_W'(s2_prod_ff[r])
                          + vmt_pkg::SUM_W'(s2_prod_ff[4+r])
                          + vmt_pkg::SUM_W'(s2_prod_ff[8+r])
                          + vmt_pkg::SUM_W'(s2_prod_ff[12+r]);
         end

         s4_action_ff <= s3_action_ff;
         s4_m33_ff    <= s3_m33_ff;
         for (int r = 0; r < 4; r++) begin
            if (row_shift[r][vmt_pkg::SUM_W-1:31] == '0 ||
                row_shift[r][vmt_pkg::SUM_W-1:31] == '1) begin
               s4_row_ff[r] <= row_shift[r][31:0];
            end else begin
               s4_row_ff[r] <= row_shift[r][vmt_pkg::SUM_W-1]
                             ? vmt_pkg::SAT_MIN : vmt_pkg::SAT_MAX;
            end
         end
      end
   end

   // chain entry: pick the divisor, seed the numerators as magnitudes
   always_comb begin
      ctrl_in.valid  = s4_valid_ff;
      ctrl_in.action = s4_action_ff;
      for (int i = 0; i < 3; i++) begin
         ctrl_in.num[i] = s4_row_ff[i];
      end
      ctrl_in.den     = (s4_action_ff == vmt_pkg::ACT_DIR) ? s4_m33_ff : s4_row_ff[3];
      ctrl_in.den_mag = ctrl_in.den[31] ? 32'(-ctrl_in.den) : 32'(ctrl_in.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NW; k++) begin
            ctrl_ff[k] <= '0;
         end
      end else if (advance) begin
         ctrl_ff[0] <= ctrl_in;
         for (int k = 1; k <= NW; k++) begin
            ctrl_ff[k] <= ctrl_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            nq_seed_ff[i] <= {(s4_row_ff[i][31] ? 32'(-s4_row_ff[i]) : 32'(s4_row_ff[i])),
                              FB'(0)};
         end
      end
   end

   for (genvar ln = 0; ln < 3; ln++) begin : g_lane
      assign rem_w[ln][0] = '0;
      assign nq_w[ln][0]  = nq_seed_ff[ln];
      for (genvar k = 0; k < NW; k++) begin : g_cell
         vmt_div_cell u_cell (
            .clock   (clock),
            .advance (advance),
            .den_mag (ctrl_ff[k].den_mag),
            .rem_in  (rem_w[ln][k]),
            .nq_in   (nq_w[ln][k]),
            .rem_ff  (rem_w[ln][k+1]),
            .nq_ff   (nq_w[ln][k+1])
         );
      end
   end

   // chain exit: sign, saturate, zero divisor, or plain rows for mode 1
   always_comb begin
      logic           neg;
      logic [NW-1:0]  q;
      logic [31:0]    lane;
      rsp_fault_in = 1'b0;
      rsp_data_in  = '0;
      rsp_data_in[127:96] = ctrl_ff[NW].den;
      for (int i = 0; i < 3; i++) begin
         q    = nq_w[i][NW];
         neg  = ctrl_ff[NW].num[i][31] ^ ctrl_ff[NW].den[31];
         lane = ctrl_ff[NW].num[i];
         if (ctrl_ff[NW].action != vmt_pkg::ACT_VEC) begin
            if (ctrl_ff[NW].den == 32'sd0) begin
               lane = ctrl_ff[NW].num[i][31] ? vmt_pkg::SAT_MIN : vmt_pkg::SAT_MAX;
            end else if (!neg) begin
               lane = (q > NW'(32'h7fffffff)) ? vmt_pkg::SAT_MAX : q[31:0];
            end else begin
               lane = (q > NW'(33'h80000000)) ? vmt_pkg::SAT_MIN : 32'(-q[31:0]);
            end
         end
         rsp_data_in[i*32 +: 32] = lane;
      end
      rsp_fault_in = ctrl_ff[NW].action != vmt_pkg::ACT_VEC && ctrl_ff[NW].den == 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctrl_ff[NW].valid;
      end
      if (advance) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_fault_ff <= rsp_fault_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fault_ff;

   // a fault always reports the zero divisor in w
   a_fault_zero_w: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[127:96] == 32'd0)
      else $error("fault with nonzero divisor");

   // a load lands in the addressed element
   a_load_write: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_action == vmt_pkg::ACT_LOAD
      |=> matrix_ff[$past(req_tdata[3:0])] == $past(req_tdata[35:4]))
      else $error("load not stored");

   // reset leaves identity in place
   a_reset_identity: assert property (@(posedge clock)
      $past(reset) && !reset |-> matrix_ff[0] == vmt_pkg::ONE && matrix_ff[1] == 32'sd0)
      else $error("matrix not identity after reset");

   // a stall freezes the chain exit
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(ctrl_ff[NW].valid) && $stable(rsp_data_ff))
      else $error("pipeline moved during stall");

endmodule
